// File: hdl/etc2_pkg.sv
// ----------------------------------------------------------------------------
// etc2_pkg
// Shared types, codes and tables for the ETC2/EAC texel decoder.
// ----------------------------------------------------------------------------
package etc2_pkg;

  typedef enum logic [2:0] {
    FMT_RGB8    = 3'd0,
    FMT_RGB8_PT = 3'd1,
    FMT_RGBA8   = 3'd2,
    FMT_R11     = 3'd3,
    FMT_R11_S   = 3'd4,
    FMT_RG11    = 3'd5,
    FMT_RG11_S  = 3'd6,
    FMT_NONE    = 3'd7
  } fmt_t;

  // classified item between front and back
  typedef struct packed {
    fmt_t        fmt;
    logic [63:0] wa;
    logic [63:0] wb;
    logic [3:0]  tx;
  } item_t;

  typedef struct packed {
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic [15:0] c1;
    logic [15:0] c2;
  } texel_t;

  localparam int QDEPTH = 2;

  function automatic logic [6:0] dist_lut(input logic [2:0] i);
    case (i)
      3'd0: dist_lut = 7'd3;
      3'd1: dist_lut = 7'd6;
      3'd2: dist_lut = 7'd11;
      3'd3: dist_lut = 7'd16;
      3'd4: dist_lut = 7'd23;
      3'd5: dist_lut = 7'd32;
      3'd6: dist_lut = 7'd41;
      default: dist_lut = 7'd64;
    endcase
  endfunction

  function automatic logic signed [3:0] delta_lut(input logic [2:0] i);
    delta_lut = $signed({i[2], i});
  endfunction

  function automatic logic signed [8:0] etc_mod_lut(input logic [2:0] t, input logic [1:0] i);
    logic [7:0] m;
    case (t)
      3'd0: m = i[0] ? 8'd8 : 8'd2;
      3'd1: m = i[0] ? 8'd17 : 8'd5;
      3'd2: m = i[0] ? 8'd29 : 8'd9;
      3'd3: m = i[0] ? 8'd42 : 8'd13;
      3'd4: m = i[0] ? 8'd60 : 8'd18;
      3'd5: m = i[0] ? 8'd80 : 8'd24;
      3'd6: m = i[0] ? 8'd106 : 8'd33;
      default: m = i[0] ? 8'd183 : 8'd47;
    endcase
    etc_mod_lut = i[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  function automatic logic signed [4:0] eac_mod_lut(input logic [3:0] t, input logic [2:0] s);
    logic [15:0] r;
    logic [3:0]  m;
    case (t)
      4'd0:  r = 16'hf963;
      4'd1:  r = 16'hda73;
      4'd2:  r = 16'hd852;
      4'd3:  r = 16'hd642;
      4'd4:  r = 16'hc863;
      4'd5:  r = 16'hb973;
      4'd6:  r = 16'hb874;
      4'd7:  r = 16'hb853;
      4'd8:  r = 16'ha862;
      4'd9:  r = 16'ha852;
      4'd10: r = 16'ha842;
      4'd11: r = 16'ha752;
      4'd12: r = 16'ha743;
      4'd13: r = 16'ha321;
      4'd14: r = 16'h9864;
      default: r = 16'h9753;
    endcase
    m = r[4*s[1:0] +: 4];
    // nibbles hold the negative magnitudes; positive half is magnitude minus one
    if (s[2]) begin
      eac_mod_lut = $signed({1'b0, m}) - 5'sd1;
    end else begin
      eac_mod_lut = -$signed({1'b0, m});
    end
  endfunction

endpackage

// File: hdl/etc2_eac_texel_decoder_core.sv
// ----------------------------------------------------------------------------
// etc2_eac_texel_decoder_core
// ETC2/EAC texel decoder: one compressed block plus texel index in, one texel out.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                          tuser
//  in       in   block_word_a, block_word_b, texel_index     -
//  out      out  red, green, blue, alpha, ch1, ch2           -
//  cfg      in   format_select (3 bits)                      -
//
// One texel per cycle sustained while the output is not stalled; a texel passes a queue entry, then the result reg.
// The two-entry queue between front and back lets input keep flowing while
// a result waits; in_tready drops only with a full queue and stalled output.
// Reset clears the queue, the output valid and format_select to rgb8.
module etc2_eac_texel_decoder_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [135:0] in_tdata,   // block_word_a, block_word_b, texel_index
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata   // red, green, blue, alpha, ch1, ch2
);
  etc2_pkg::fmt_t  fmt_r;
  etc2_pkg::item_t q_item;
  etc2_pkg::texel_t tex;
  logic q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) fmt_r <= etc2_pkg::FMT_RGB8;
    else if (cfg_we) fmt_r <= etc2_pkg::fmt_t'(cfg_wdata);
  end

  etc2_front u_front (
    .clk(clk), .rst_n(rst_n), .fmt(fmt_r), .in_valid(in_tvalid), .in_ready(in_tready),
    .wa(in_tdata[63:0]), .wb(in_tdata[127:64]), .tx(in_tdata[131:128]),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  etc2_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_texel(tex)
  );

  assign out_tdata = {tex.c2, tex.c1, tex.a, tex.b, tex.g, tex.r};

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> in_tready) else $error("stall with empty queue");
endmodule

// File: hdl/etc2_front.sv
// ----------------------------------------------------------------------------
// etc2_front
// Accepts blocks, tags them with the format and pushes them into a short queue.
// ----------------------------------------------------------------------------
module etc2_front (
  input  logic            clk,
  input  logic            rst_n,
  input  etc2_pkg::fmt_t  fmt,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [63:0]     wa,
  input  logic [63:0]     wb,
  input  logic [3:0]      tx,
  output logic            q_valid,
  input  logic            q_pop,
  output etc2_pkg::item_t q_item
);
  localparam int AW = $clog2(etc2_pkg::QDEPTH);
  etc2_pkg::item_t mem_r [etc2_pkg::QDEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic push;

  assign in_ready = (cnt_r != (AW+1)'(etc2_pkg::QDEPTH)) || q_pop;
  assign push     = in_valid && in_ready;
  assign q_valid  = cnt_r != '0;
  assign q_item   = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(q_pop && q_valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop && q_valid) rp_r <= rp_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{fmt: fmt, wa: wa, wb: wb, tx: tx};
  end
endmodule

// File: hdl/etc2_color.sv
// ----------------------------------------------------------------------------
// etc2_color
// ETC2 RGB color decode for one texel: individual, differential, T, H, planar.
// ----------------------------------------------------------------------------
module etc2_color (
  input  logic [63:0] w,
  input  logic        pt,
  input  logic [3:0]  t,
  output logic [7:0]  r,
  output logic [7:0]  g,
  output logic [7:0]  b,
  output logic [7:0]  a
);
  function automatic logic [7:0] clamp8(input logic signed [11:0] v);
    clamp8 = v < 0 ? 8'd0 : (v > 12'sd255 ? 8'd255 : v[7:0]);
  endfunction
  function automatic logic [7:0] e4(input logic [3:0] v); e4 = {v, v}; endfunction
  function automatic logic [7:0] e6(input logic [5:0] v); e6 = {v, v[5:4]}; endfunction
  function automatic logic [7:0] e7(input logic [6:0] v); e7 = {v, v[6]}; endfunction
  function automatic logic [7:0] plane(input logic [7:0] o, input logic [7:0] h,
                                       input logic [7:0] v, input logic [1:0] x,
                                       input logic [1:0] y);
    logic signed [13:0] s;
    s = $signed({4'd0, x}) * ($signed({6'd0, h}) - $signed({6'd0, o}))
      + $signed({4'd0, y}) * ($signed({6'd0, v}) - $signed({6'd0, o}))
      + $signed({4'd0, o, 2'b00}) + 14'sd2;
    plane = clamp8(12'(s >>> 2));
  endfunction

  logic [7:0] b0, b1, b2, b3;
  logic [15:0] msb, lsb;
  logic [1:0] idx, x, y;
  logic dbit, opaque, indiv, rov, gov, bov, sub, flip;
  logic signed [6:0] rs, gs, bs;
  logic [2:0] tab;
  logic signed [8:0] md;
  logic [7:0] t1 [3], t2 [3], bse [3], hc1 [3], hc2 [3];
  logic [6:0] d;
  logic [23:0] v1, v2;
  logic [5:0] cs;

  always_comb begin
    b0 = w[63:56]; b1 = w[55:48]; b2 = w[47:40]; b3 = w[39:32];
    msb = w[31:16]; lsb = w[15:0];
    x = t[3:2]; y = t[1:0];
    idx = {msb[t], lsb[t]};
    dbit = b3[1];
    opaque = !pt || dbit;
    indiv = !pt && !dbit;
    rs = $signed({2'b0, b0[7:3]}) + 7'(etc2_pkg::delta_lut(b0[2:0]));
    gs = $signed({2'b0, b1[7:3]}) + 7'(etc2_pkg::delta_lut(b1[2:0]));
    bs = $signed({2'b0, b2[7:3]}) + 7'(etc2_pkg::delta_lut(b2[2:0]));
    rov = rs < 0 || rs > 7'sd31;
    gov = gs < 0 || gs > 7'sd31;
    bov = bs < 0 || bs > 7'sd31;
    flip = b3[0];
    sub = flip ? y[1] : x[1];
    tab = sub ? b3[4:2] : b3[7:5];
    md = (!opaque && idx == 2'd0) ? 9'sd0 : etc2_pkg::etc_mod_lut(tab, idx);
    // T mode colors
    t1[0] = e4({b0[4:3], b0[1:0]}); t1[1] = e4(b1[7:4]); t1[2] = e4(b1[3:0]);
    t2[0] = e4(b2[7:4]); t2[1] = e4(b2[3:0]); t2[2] = e4(b3[7:4]);
    // H mode colors
    hc1[0] = e4(b0[6:3]); hc1[1] = e4({b0[2:0], b1[4]});
    hc1[2] = e4({b1[3], b1[1:0], b2[7]});
    hc2[0] = e4(b2[6:3]); hc2[1] = e4({b2[2:0], b3[7]}); hc2[2] = e4(b3[6:3]);
    v1 = {hc1[0], hc1[1], hc1[2]};
    v2 = {hc2[0], hc2[1], hc2[2]};
    d = 7'd0;
    if (rov) d = etc2_pkg::dist_lut({b3[3:2], b3[0]});
    else     d = etc2_pkg::dist_lut({b3[2], b3[0], v1 >= v2});
    r = 8'd0; g = 8'd0; b = 8'd0; a = 8'd255;
    for (int c = 0; c < 3; c++) begin
      cs = '0;
      case (c)
        0: cs = 6'(rs);
        1: cs = 6'(gs);
        default: cs = 6'(bs);
      endcase
      if (indiv) begin
        bse[c] = e4(sub ? w[59-8*c -: 4] : w[63-8*c -: 4]);
      end else begin
        bse[c] = sub ? {cs[4:0], cs[4:2]} : {w[63-8*c -: 5], w[63-8*c -: 3]};
      end
    end
    if (!opaque && idx == 2'd2 && !(!indiv && !rov && !gov && bov)) begin
      a = 8'd0;
    end else if (!indiv && rov) begin
      for (int c = 0; c < 3; c++) begin
        logic [7:0] pv;
        pv = '0;
        case (idx)
          2'd0: pv = clamp8($signed({4'd0, t1[c]}));
          2'd1: pv = clamp8($signed({4'd0, t2[c]}) + $signed({5'd0, d}));
          2'd2: pv = clamp8($signed({4'd0, t2[c]}));
          default: pv = clamp8($signed({4'd0, t2[c]}) - $signed({5'd0, d}));
        endcase
        case (c) 0: r = pv; 1: g = pv; default: b = pv; endcase
      end
    end else if (!indiv && gov) begin
      for (int c = 0; c < 3; c++) begin
        logic [7:0] pv;
        pv = '0;
        case (idx)
          2'd0: pv = clamp8($signed({4'd0, hc1[c]}) + $signed({5'd0, d}));
          2'd1: pv = clamp8($signed({4'd0, hc1[c]}) - $signed({5'd0, d}));
          2'd2: pv = clamp8($signed({4'd0, hc2[c]}) + $signed({5'd0, d}));
          default: pv = clamp8($signed({4'd0, hc2[c]}) - $signed({5'd0, d}));
        endcase
        case (c) 0: r = pv; 1: g = pv; default: b = pv; endcase
      end
    end else if (!indiv && bov) begin
      r = plane(e6(b0[6:1]), e6({b3[6:2], b3[0]}), e6({w[18:16], w[15:13]}), x, y);
      g = plane(e7({b0[0], b1[6:1]}), e7(w[31:25]), e7({w[12:8], w[7:6]}), x, y);
      b = plane(e6({b1[0], b2[4:3], b2[1:0], b3[7]}), e6({w[24], w[23:19]}),
                e6(w[5:0]), x, y);
    end else begin
      r = clamp8($signed({4'd0, bse[0]}) + 12'(md));
      g = clamp8($signed({4'd0, bse[1]}) + 12'(md));
      b = clamp8($signed({4'd0, bse[2]}) + 12'(md));
    end
  end
endmodule

// File: hdl/etc2_eac.sv
// ----------------------------------------------------------------------------
// etc2_eac
// EAC channel decode for one texel: 8-bit alpha and 11-bit r/g expanded to 16.
// ----------------------------------------------------------------------------
module etc2_eac (
  input  logic [63:0] w,
  input  logic [3:0]  t,
  input  logic        sgn,
  output logic [7:0]  alpha,
  output logic [15:0] value
);
  logic [7:0] b0;
  logic [3:0] mult;
  logic [2:0] sel;
  logic signed [4:0] md;
  logic signed [12:0] sc, v, base, av;
  logic [10:0] vu, mag;
  logic [15:0] ex;

  always_comb begin
    b0 = w[63:56];
    mult = w[55:52];
    sel = w[47 - 3*t -: 3];
    md = etc2_pkg::eac_mod_lut(w[51:48], sel);
    sc = (mult != 4'd0) ? 13'(md) * $signed({9'd0, mult}) * 13'sd8 : 13'(md);
    av = $signed({5'd0, b0}) + 13'(md) * $signed({9'd0, mult});
    alpha = av < 0 ? 8'd0 : (av > 13'sd255 ? 8'd255 : av[7:0]);
    base = $signed({{5{b0[7]}}, b0});
    if (base < -13'sd127) base = -13'sd127;
    if (!sgn) begin
      v = $signed({2'd0, b0, 3'd4}) + sc;
      vu = v < 0 ? 11'd0 : (v > 13'sd2047 ? 11'd2047 : v[10:0]);
      value = {vu, vu[10:6]};
      mag = '0; ex = '0;
    end else begin
      v = base * 13'sd8 + sc;
      if (v < -13'sd1023) v = -13'sd1023;
      if (v > 13'sd1023) v = 13'sd1023;
      mag = v < 0 ? 11'(-v) : v[10:0];
      ex = {mag, 5'd0} | 16'(mag >> 5);
      vu = '0;
      value = v < 0 ? 16'(17'h10000 - {1'b0, ex}) : ex;
    end
  end
endmodule

// File: hdl/etc2_back.sv
// ----------------------------------------------------------------------------
// etc2_back
// Pops a queued item, decodes it per format and holds the result register.
// ----------------------------------------------------------------------------
module etc2_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_pop,
  input  etc2_pkg::item_t  q_item,
  output logic             out_valid,
  input  logic             out_ready,
  output etc2_pkg::texel_t out_texel
);
  logic [63:0] cw;
  logic pt;
  logic [7:0] r, g, b, a, ea, unused_a;
  logic [15:0] c1, c2;
  logic s;
  logic valid_r;
  etc2_pkg::texel_t tex_r, tex_nxt;

  always_comb begin
    cw = (q_item.fmt == etc2_pkg::FMT_RGBA8) ? q_item.wb : q_item.wa;
    pt = q_item.fmt == etc2_pkg::FMT_RGB8_PT;
    s  = q_item.fmt == etc2_pkg::FMT_R11_S || q_item.fmt == etc2_pkg::FMT_RG11_S;
  end

  etc2_color u_color (.w(cw), .pt(pt), .t(q_item.tx), .r(r), .g(g), .b(b), .a(a));
  etc2_eac u_eac_a (.w(q_item.wa), .t(q_item.tx), .sgn(s), .alpha(ea), .value(c1));
  etc2_eac u_eac_b (.w(q_item.wb), .t(q_item.tx), .sgn(s), .alpha(unused_a), .value(c2));

  assign q_pop = q_valid && (!valid_r || out_ready);

  always_comb begin
    tex_nxt = '0;
    case (q_item.fmt)
      etc2_pkg::FMT_RGB8, etc2_pkg::FMT_RGB8_PT: tex_nxt = '{r, g, b, a, 16'd0, 16'd0};
      etc2_pkg::FMT_RGBA8: tex_nxt = '{r, g, b, ea, 16'd0, 16'd0};
      etc2_pkg::FMT_R11, etc2_pkg::FMT_R11_S: tex_nxt = '{8'd0, 8'd0, 8'd0, 8'd0, c1, 16'd0};
      etc2_pkg::FMT_RG11, etc2_pkg::FMT_RG11_S:
        tex_nxt = '{8'd0, 8'd0, 8'd0, unused_a & 8'd0, c1, c2};
      default: tex_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else if (q_pop) valid_r <= 1'b1;
    else if (out_ready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) tex_r <= tex_nxt;
  end

  assign out_valid = valid_r;
  assign out_texel = tex_r;
endmodule
